### design/csle_pkg.sv
// Shared types, character constants and helper functions for the C string escaper.
`timescale 1ns / 1ps

package csle_pkg;

  // Characters used by the escaper
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_LOWER_X   = 8'h78;
  localparam logic [7:0] CHR_UPPER_X   = 8'h58;
  localparam logic [7:0] CHR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHR_ZERO      = 8'h30;
  localparam logic [7:0] CHR_NONE      = 8'h00;
  localparam logic [7:0] PRINT_LOW     = 8'h20;
  localparam logic [7:0] PRINT_HIGH    = 8'h7E;
  localparam logic [3:0] NIBBLE_MAX_DEC = 4'd9;
  localparam logic [2:0] HIST_FULL     = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       starts_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } out_item_t;

  // Expansion of one input byte
  typedef enum logic [1:0] {
    JOB_LIT  = 2'd0,  // byte passes through
    JOB_PAIR = 2'd1,  // backslash + letter
    JOB_HEX  = 2'd2   // backslash, x, two hex digits
  } job_kind_t;

  typedef struct packed {
    job_kind_t       kind;
    logic [3:0][7:0] bytes;  // bytes[0] goes out first
  } job_t;

  function automatic logic is_hex_digit(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v <= NIBBLE_MAX_DEC) begin
      return CHR_ZERO + {4'd0, v};
    end else begin
      return CHR_UPPER_A + {4'd0, v} - 8'd10;
    end
  endfunction

  // Letter after the backslash for simple escapes, CHR_NONE otherwise
  function automatic logic [7:0] escape_letter(input logic [7:0] c);
    logic [7:0] l;
    case (c)
      8'h22:   l = 8'h22;  // "
      8'h3F:   l = 8'h3F;  // ?
      8'h5C:   l = 8'h5C;  // backslash
      8'h07:   l = 8'h61;  // a
      8'h08:   l = 8'h62;  // b
      8'h0C:   l = 8'h66;  // f
      8'h0A:   l = 8'h6E;  // n
      8'h0D:   l = 8'h72;  // r
      8'h09:   l = 8'h74;  // t
      8'h0B:   l = 8'h76;  // v
      default: l = CHR_NONE;
    endcase
    return l;
  endfunction

  // Index of the final byte of a job
  function automatic logic [1:0] last_index(input job_kind_t k);
    logic [1:0] r;
    case (k)
      JOB_LIT:  r = 2'd0;
      JOB_PAIR: r = 2'd1;
      JOB_HEX:  r = 2'd3;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

### design/csle_front.sv
// Front end: classifies each input item, tracks emitted-byte history, builds jobs.
`timescale 1ns / 1ps

module csle_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  csle_pkg::in_item_t item,
  output csle_pkg::job_t     job
);

  logic [31:0] hist;
  logic [31:0] hist_next;
  logic [2:0]  cnt;
  logic [2:0]  cnt_next;

  logic [31:0] eff_hist;
  logic [2:0]  eff_cnt;
  logic [7:0]  c;
  logic [7:0]  letter;
  logic        hist_esc;
  logic        escape;
  logic [2:0]  cnt_add;

  always_comb begin
    c        = item.in_byte;
    eff_hist = item.starts_string ? 32'd0 : hist;
    eff_cnt  = item.starts_string ? 3'd0 : cnt;
    letter   = csle_pkg::escape_letter(c);

    // \x followed by two hex digits: a further hex digit would extend it
    hist_esc = csle_pkg::is_hex_digit(c) && (eff_cnt == csle_pkg::HIST_FULL) &&
               (eff_hist[31:24] == csle_pkg::CHR_BACKSLASH) &&
               ((eff_hist[23:16] == csle_pkg::CHR_LOWER_X) ||
                (eff_hist[23:16] == csle_pkg::CHR_UPPER_X)) &&
               csle_pkg::is_hex_digit(eff_hist[15:8]) &&
               csle_pkg::is_hex_digit(eff_hist[7:0]);
    escape = (c < csle_pkg::PRINT_LOW) || (c > csle_pkg::PRINT_HIGH) || hist_esc;

    job.bytes = '0;
    if (letter != csle_pkg::CHR_NONE) begin
      job.kind     = csle_pkg::JOB_PAIR;
      job.bytes[0] = csle_pkg::CHR_BACKSLASH;
      job.bytes[1] = letter;
      hist_next    = {eff_hist[15:0], csle_pkg::CHR_BACKSLASH, letter};
      cnt_add      = eff_cnt + 3'd2;
    end else if (escape) begin
      job.kind     = csle_pkg::JOB_HEX;
      job.bytes[0] = csle_pkg::CHR_BACKSLASH;
      job.bytes[1] = csle_pkg::CHR_LOWER_X;
      job.bytes[2] = csle_pkg::hex_char(c[7:4]);
      job.bytes[3] = csle_pkg::hex_char(c[3:0]);
      hist_next    = {job.bytes[0], job.bytes[1], job.bytes[2], job.bytes[3]};
      cnt_add      = csle_pkg::HIST_FULL;
    end else begin
      job.kind     = csle_pkg::JOB_LIT;
      job.bytes[0] = c;
      hist_next    = {eff_hist[23:0], c};
      cnt_add      = eff_cnt + 3'd1;
    end
    cnt_next = (cnt_add > csle_pkg::HIST_FULL) ? csle_pkg::HIST_FULL : cnt_add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
      cnt  <= '0;
    end else if (accept) begin
      hist <= hist_next;
      cnt  <= cnt_next;
    end
  end

endmodule

### design/csle_queue.sv
// Small job FIFO between the front end and the serializer.
`timescale 1ns / 1ps

module csle_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csle_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output csle_pkg::job_t head_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  csle_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");
`endif

endmodule

### design/csle_back.sv
// Back end: serializes queued jobs to an output register, one byte per cycle when ready.
`timescale 1ns / 1ps

module csle_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  csle_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output csle_pkg::out_item_t out_item
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign is_last = (idx == csle_pkg::last_index(head_job.kind));
  assign load    = head_valid && (!out_valid || out_ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.out_byte <= head_job.bytes[idx];
      out_item.run_end  <= is_last;
    end
  end

`ifndef SYNTHESIS
  a_mid_job_has_head: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd0 |-> head_valid)
    else $error("serializer mid-job with empty queue");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == 2'd0)
    else $error("byte index not cleared after final byte");

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= csle_pkg::last_index(head_job.kind))
    else $error("byte index past end of job");
`endif

endmodule

### design/c_string_literal_escaper_unit.sv
// C string literal escaper top level. Each input item carries one raw byte of a
// string plus a flag that marks the first byte of a new string; the block emits
// the escaped form as a stream of output items, one byte each, with run_end set
// on the final byte belonging to an input byte. Quote, question mark and
// backslash become backslash + the character, BEL/BS/FF/LF/CR/TAB/VT become
// backslash + letter, non-printable bytes become \xHH with upper-case digits, and
// a hex digit that would otherwise extend a preceding \xHH is itself hex-escaped.
// Each input byte yields 1, 2 or 4 output items, and the output port moves one
// byte per cycle while esc_ready is high, so an item costs 1 to 4 bytes of
// output bandwidth. The front end takes a new item every cycle as long as the
// job queue (QUEUE_DEPTH entries) has room; the serializer behind it drains the
// queue into a registered output stage. Bytes after reset behave as if a string
// had just started.
`timescale 1ns / 1ps

module c_string_literal_escaper_unit #(
  parameter int QUEUE_DEPTH = 2  // job queue entries, 2 or more
) (
  input  logic                clk,
  input  logic                rst,
  // raw byte items
  input  logic                byte_valid,
  output logic                byte_ready,
  input  csle_pkg::in_item_t  byte_item,
  // escaped byte items
  output logic                esc_valid,
  input  logic                esc_ready,
  output csle_pkg::out_item_t esc_item
);

  logic           accept;
  logic           q_full;
  logic           q_pop;
  logic           q_head_valid;
  csle_pkg::job_t new_job;
  csle_pkg::job_t head_job;

  // Front end stalls only when the queue is full; nothing is taken during reset
  assign byte_ready = !q_full && !rst;
  assign accept     = byte_valid && byte_ready;

  // Classification and history tracking; history advances at accept time,
  // independent of when the bytes actually leave the output port.
  csle_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .job    (new_job)
  );

  csle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_job   (new_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (head_job)
  );

  // Serializer; pops a job once its last byte is loaded into the output register
  csle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (esc_valid),
    .out_ready  (esc_ready),
    .out_item   (esc_item)
  );

endmodule
